[rtl/irpw_pkg.sv]
package irpw_pkg;

  localparam int unsigned TickW  = 12;
  localparam int unsigned FrameW = 16;
  localparam int unsigned CountW = 6;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  localparam logic [TickW-1:0]  TickMax  = '1;
  localparam logic [FrameW-1:0] FrameMax = '1;
  localparam logic [CountW-1:0] CountMax = '1;
  localparam logic [CountW-1:0] ByteBits = CountW'(ByteW);

  // event kinds on the input channel
  localparam logic KindTick = 1'b0;
  localparam logic KindEdge = 1'b1;

  // register reset values
  localparam logic [TickW-1:0]  StartNominalRst   = 12'd2;
  localparam logic [TickW-1:0]  StartToleranceRst = 12'd1;
  localparam logic [TickW-1:0]  EndNominalRst     = 12'd2;
  localparam logic [TickW-1:0]  EndToleranceRst   = 12'd1;
  localparam logic [TickW-1:0]  ZeroNominalRst    = 12'd17;
  localparam logic [TickW-1:0]  OneNominalRst     = 12'd22;
  localparam logic [TickW-1:0]  BitToleranceRst   = 12'd2;
  localparam logic [FrameW-1:0] FrameTimeoutRst   = 16'd500;

  typedef enum logic [2:0] {
    REG_START_NOMINAL   = 3'd0,
    REG_START_TOLERANCE = 3'd1,
    REG_END_NOMINAL     = 3'd2,
    REG_END_TOLERANCE   = 3'd3,
    REG_ZERO_NOMINAL    = 3'd4,
    REG_ONE_NOMINAL     = 3'd5,
    REG_BIT_TOLERANCE   = 3'd6,
    REG_FRAME_TIMEOUT   = 3'd7
  } irpw_reg_t;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_END_FIRST   = 3'd1,
    PH_START_START = 3'd2,
    PH_END_START   = 3'd3,
    PH_START_END   = 3'd4,
    PH_END_END     = 3'd5,
    PH_HALTED      = 3'd6
  } irpw_phase_t;

  typedef struct packed {
    logic [TickW-1:0]  start_nominal;
    logic [TickW-1:0]  start_tolerance;
    logic [TickW-1:0]  end_nominal;
    logic [TickW-1:0]  end_tolerance;
    logic [TickW-1:0]  zero_nominal;
    logic [TickW-1:0]  one_nominal;
    logic [TickW-1:0]  bit_tolerance;
    logic [FrameW-1:0] frame_timeout;
  } irpw_cfg_t;

endpackage

[rtl/irpw_if.sv]
interface irpw_event_if;
  logic valid;
  logic ready;
  logic kind;
  logic level;

  modport source (output valid, output kind, output level, input ready);
  modport sink (input valid, input kind, input level, output ready);
endinterface

interface irpw_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [5:0] bits_received;
  logic       too_many_bits;

  modport source (output valid, output data_byte, output bits_received,
                  output too_many_bits, input ready);
  modport sink (input valid, input data_byte, input bits_received,
                input too_many_bits, output ready);
endinterface

[rtl/irpw_cfg_regs.sv]
module irpw_cfg_regs (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [irpw_pkg::AddrW-1:0] paddr,
  input  logic [irpw_pkg::DataW-1:0] pwdata,
  output logic [irpw_pkg::DataW-1:0] prdata,
  output logic                    pready,
  output irpw_pkg::irpw_cfg_t     cfg
);
  import irpw_pkg::*;

  irpw_reg_t reg_sel;
  logic      wr_en;

  assign pready  = 1'b1;
  assign reg_sel = irpw_reg_t'(paddr[AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_nominal   <= StartNominalRst;
      cfg.start_tolerance <= StartToleranceRst;
      cfg.end_nominal     <= EndNominalRst;
      cfg.end_tolerance   <= EndToleranceRst;
      cfg.zero_nominal    <= ZeroNominalRst;
      cfg.one_nominal     <= OneNominalRst;
      cfg.bit_tolerance   <= BitToleranceRst;
      cfg.frame_timeout   <= FrameTimeoutRst;
    end else if (wr_en) begin
      case (reg_sel)
        REG_START_NOMINAL:   cfg.start_nominal   <= pwdata[TickW-1:0];
        REG_START_TOLERANCE: cfg.start_tolerance <= pwdata[TickW-1:0];
        REG_END_NOMINAL:     cfg.end_nominal     <= pwdata[TickW-1:0];
        REG_END_TOLERANCE:   cfg.end_tolerance   <= pwdata[TickW-1:0];
        REG_ZERO_NOMINAL:    cfg.zero_nominal    <= pwdata[TickW-1:0];
        REG_ONE_NOMINAL:     cfg.one_nominal     <= pwdata[TickW-1:0];
        REG_BIT_TOLERANCE:   cfg.bit_tolerance   <= pwdata[TickW-1:0];
        REG_FRAME_TIMEOUT:   cfg.frame_timeout   <= pwdata[FrameW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_START_NOMINAL:   prdata = DataW'(cfg.start_nominal);
      REG_START_TOLERANCE: prdata = DataW'(cfg.start_tolerance);
      REG_END_NOMINAL:     prdata = DataW'(cfg.end_nominal);
      REG_END_TOLERANCE:   prdata = DataW'(cfg.end_tolerance);
      REG_ZERO_NOMINAL:    prdata = DataW'(cfg.zero_nominal);
      REG_ONE_NOMINAL:     prdata = DataW'(cfg.one_nominal);
      REG_BIT_TOLERANCE:   prdata = DataW'(cfg.bit_tolerance);
      REG_FRAME_TIMEOUT:   prdata = DataW'(cfg.frame_timeout);
      default:             prdata = '0;
    endcase
  end

endmodule

[rtl/irpw_core.sv]
module irpw_core (
  input  logic                clk,
  input  logic                rst,
  input  irpw_pkg::irpw_cfg_t cfg,
  irpw_event_if.sink          evt,
  irpw_result_if.source       result
);
  import irpw_pkg::*;

  irpw_phase_t       phase, phase_next;
  logic [TickW-1:0]  elapsed_ticks;
  logic [FrameW-1:0] frame_ticks;
  logic              frame_armed;
  logic [ByteW-1:0]  shift_byte;
  logic [CountW-1:0] bit_count;

  logic              res_valid;
  logic [ByteW-1:0]  res_byte;
  logic [CountW-1:0] res_count;
  logic              res_many;

  logic              accept, tick_acc, edge_acc;
  logic [FrameW-1:0] ft_inc;
  logic              expire;
  logic              start_ok, end_ok, zero_ok, one_ok;
  logic              clr_byte, arm, shift_en, shift_val;

  // nominal-tol <= len <= nominal+tol, evaluated one bit wider so nothing wraps
  function automatic logic in_window(input logic [TickW-1:0] len,
                                     input logic [TickW-1:0] nom,
                                     input logic [TickW-1:0] tol);
    logic [TickW:0] lo_side;
    logic [TickW:0] hi_side;
    lo_side = {1'b0, len} + {1'b0, tol};
    hi_side = {1'b0, nom} + {1'b0, tol};
    return (lo_side >= {1'b0, nom}) && ({1'b0, len} <= hi_side);
  endfunction

  // output register frees up whenever the result is taken
  assign evt.ready = !res_valid || result.ready;
  assign accept    = evt.valid && evt.ready;
  assign tick_acc  = accept && (evt.kind == KindTick);
  assign edge_acc  = accept && (evt.kind == KindEdge);

  assign ft_inc = (frame_ticks == FrameMax) ? frame_ticks : frame_ticks + 1'b1;
  assign expire = tick_acc && frame_armed && (ft_inc >= cfg.frame_timeout);

  assign start_ok = in_window(elapsed_ticks, cfg.start_nominal, cfg.start_tolerance);
  assign end_ok   = in_window(elapsed_ticks, cfg.end_nominal, cfg.end_tolerance);
  assign zero_ok  = in_window(elapsed_ticks, cfg.zero_nominal, cfg.bit_tolerance);
  assign one_ok   = in_window(elapsed_ticks, cfg.one_nominal, cfg.bit_tolerance);

  always_comb begin
    phase_next = phase;
    if (expire) begin
      phase_next = PH_IDLE;
    end else if (edge_acc) begin
      case (phase)
        PH_IDLE: begin
          if (!evt.level) phase_next = PH_END_FIRST;
        end
        PH_END_FIRST: begin
          phase_next = (evt.level && start_ok) ? PH_START_END : PH_IDLE;
        end
        PH_START_START: begin
          phase_next = evt.level ? PH_HALTED : PH_END_START;
        end
        PH_END_START: begin
          phase_next = (evt.level && start_ok) ? PH_START_END : PH_HALTED;
        end
        PH_START_END: begin
          phase_next = evt.level ? PH_HALTED : PH_END_END;
        end
        PH_END_END: begin
          phase_next = (evt.level && end_ok) ? PH_START_START : PH_HALTED;
        end
        default: phase_next = phase;
      endcase
    end
  end

  always_comb begin
    clr_byte  = 1'b0;
    arm       = 1'b0;
    shift_en  = 1'b0;
    shift_val = 1'b0;
    if (edge_acc) begin
      case (phase)
        PH_IDLE:      clr_byte = !evt.level;
        PH_END_FIRST: arm = evt.level && start_ok;
        PH_START_END: begin
          // zero window has priority over the one window
          shift_en  = !evt.level && (zero_ok || one_ok);
          shift_val = !zero_ok;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      elapsed_ticks <= '0;
      frame_ticks   <= '0;
      frame_armed   <= 1'b0;
      shift_byte    <= '0;
      bit_count     <= '0;
      res_valid     <= 1'b0;
    end else begin
      phase <= phase_next;

      if (edge_acc) begin
        elapsed_ticks <= '0;
      end else if (tick_acc && elapsed_ticks != TickMax) begin
        elapsed_ticks <= elapsed_ticks + 1'b1;
      end

      if (arm) begin
        frame_ticks <= '0;
      end else if (tick_acc && frame_armed) begin
        frame_ticks <= ft_inc;
      end

      if (arm) begin
        frame_armed <= 1'b1;
      end else if (expire) begin
        frame_armed <= 1'b0;
      end

      if (clr_byte) begin
        shift_byte <= '0;
      end else if (shift_en) begin
        shift_byte <= {shift_byte[ByteW-2:0], shift_val};
      end

      if (arm) begin
        bit_count <= '0;
      end else if (shift_en && bit_count != CountMax) begin
        bit_count <= bit_count + 1'b1;
      end

      if (expire) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (expire) begin
      res_byte  <= shift_byte;
      res_count <= bit_count;
      res_many  <= bit_count > ByteBits;
    end
  end

  assign result.valid         = res_valid;
  assign result.data_byte     = res_byte;
  assign result.bits_received = res_count;
  assign result.too_many_bits = res_many;

  a_expire_emits: assert property (@(posedge clk) disable iff (rst)
    expire |=> res_valid && phase == PH_IDLE && !frame_armed)
    else $error("frame expiry did not produce a result");

  a_disarmed_phase: assert property (@(posedge clk) disable iff (rst)
    !frame_armed |-> (phase == PH_IDLE || phase == PH_END_FIRST))
    else $error("decoding phase active without frame timer");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !evt.ready |-> res_valid && !result.ready)
    else $error("input stalled with free result register");

  a_flag_matches_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_many == (res_count > ByteBits)))
    else $error("over-eight flag disagrees with bit count");

endmodule

[rtl/ir_pulse_width_byte_decoder.sv]
// infrared remote pulse-width decoder, one byte per frame
//
// evt carries one event per request: kind 0 is a 0.1 ms tick, kind 1 is an
// edge on the receiver pin with level giving the pin state after the edge.
// result carries one request per frame: the last eight bits shifted in
// (newest in bit 0), the number of classified bits (saturating at 63) and
// a flag that is set when more than eight bits arrived.
// each event is processed in the cycle it is accepted; one event per clock
// is sustained while no result waits. the result register is loaded by the
// tick on which the frame timer expires and shows up on result in the next
// cycle. while a result waits with result.ready low, evt.ready is low and no
// event of any kind is taken; the register is refilled in the same cycle it
// is drained, so a receiver that keeps ready high never stalls evt.
// registers sit on the apb port at 4*index; write them only while idle.
// rst (synchronous) restores register defaults, returns the decoder to
// idle with the frame timer disarmed and drops any pending result.
module ir_pulse_width_byte_decoder (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [irpw_pkg::AddrW-1:0] paddr,
  input  logic [irpw_pkg::DataW-1:0] pwdata,
  output logic [irpw_pkg::DataW-1:0] prdata,
  output logic                       pready,
  irpw_event_if.sink                 evt,
  irpw_result_if.source              result
);
  import irpw_pkg::*;

  irpw_cfg_t cfg;

  irpw_cfg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  irpw_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .evt    (evt),
    .result (result)
  );

endmodule

[tb/sv/tb_ir_pulse_width_byte_decoder.sv]
module tb_ir_pulse_width_byte_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import irpw_pkg::*;

  localparam int Settle = 4;
  localparam int HoldOff = 600;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [5:0] bits_received;
    logic       too_many_bits;
  } byte_frame_t;

  // one directed request; typed marks a row whose frame is written out by hand
  typedef struct packed {
    logic       kind;
    logic       level;
    logic       typed;
    logic [7:0] data_byte;
    logic [5:0] bits_received;
    logic       too_many_bits;
  } probe_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic pready;

  irpw_event_if  evt_bus ();
  irpw_result_if res_bus ();

  ir_pulse_width_byte_decoder dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .evt     (evt_bus),
    .result  (res_bus)
  );

  // decoder state as the predictor sees it
  irpw_cfg_t     cfg = '{StartNominalRst, StartToleranceRst, EndNominalRst, EndToleranceRst,
                         ZeroNominalRst, OneNominalRst, BitToleranceRst, FrameTimeoutRst};
  irpw_phase_t   ph = PH_IDLE;
  logic [TickW-1:0]  since_edge = '0;
  logic [FrameW-1:0] frame_count = '0;
  logic              armed = 1'b0;
  logic [ByteW-1:0]  shreg = '0;
  logic [CountW-1:0] nbits = '0;

  byte_frame_t frames_due[$];
  byte_frame_t want;
  byte_frame_t given;
  bit given_on = 1'b0;
  bit stall_req = 1'b0;
  int burst_left = 0;
  int events_sent = 0;
  int frames_checked = 0;
  int settings_used = 0;
  int mismatches = 0;

  // zero window [0,0], one window [1,1], start and end windows [0,0], timer 3
  probe_t probes[26] = '{
    '{KindEdge, 1'b1, 1'b0, 8'h00, 6'd0, 1'b0},
    '{KindEdge, 1'b0, 1'b0, 8'h00, 6'd0, 1'b0},
    '{KindEdge, 1'b1, 1'b0, 8'h00, 6'd0, 1'b0},
    '{KindEdge, 1'b0, 1'b0, 8'h00, 6'd0, 1'b0},
    '{KindEdge, 1'b1, 1'b0, 8'h00, 6'd0, 1'b0},
    '{KindEdge, 1'b0, 1'b0, 8'h00, 6'd0, 1'b0},
    '{KindEdge, 1'b1, 1'b0, 8'h00, 6'd0, 1'b0},
    '{KindTick, 1'b0, 1'b0, 8'h00, 6'd0, 1'b0},
    '{KindEdge, 1'b0, 1'b0, 8'h00, 6'd0, 1'b0},
    '{KindEdge, 1'b1, 1'b0, 8'h00, 6'd0, 1'b0},
    '{KindEdge, 1'b0, 1'b0, 8'h00, 6'd0, 1'b0},
    '{KindTick, 1'b1, 1'b0, 8'h00, 6'd0, 1'b0},
    '{KindEdge, 1'b1, 1'b0, 8'h00, 6'd0, 1'b0},
    '{KindEdge, 1'b0, 1'b0, 8'h00, 6'd0, 1'b0},
    '{KindTick, 1'b0, 1'b1, 8'h01, 6'd2, 1'b0},
    '{KindEdge, 1'b0, 1'b0, 8'h00, 6'd0, 1'b0},
    '{KindTick, 1'b1, 1'b0, 8'h00, 6'd0, 1'b0},
    '{KindEdge, 1'b1, 1'b0, 8'h00, 6'd0, 1'b0},
    '{KindEdge, 1'b0, 1'b0, 8'h00, 6'd0, 1'b0},
    '{KindEdge, 1'b1, 1'b0, 8'h00, 6'd0, 1'b0},
    '{KindTick, 1'b0, 1'b0, 8'h00, 6'd0, 1'b0},
    '{KindTick, 1'b0, 1'b0, 8'h00, 6'd0, 1'b0},
    '{KindEdge, 1'b0, 1'b0, 8'h00, 6'd0, 1'b0},
    '{KindEdge, 1'b0, 1'b0, 8'h00, 6'd0, 1'b0},
    '{KindTick, 1'b1, 1'b1, 8'h00, 6'd0, 1'b0},
    '{KindEdge, 1'b1, 1'b0, 8'h00, 6'd0, 1'b0}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit fits(logic [TickW-1:0] len, logic [TickW-1:0] nom,
                              logic [TickW-1:0] tol);
    int l;
    int n;
    int t;
    l = len;
    n = nom;
    t = tol;
    return l >= n - t && l <= n + t;
  endfunction

  function automatic void take_bit(logic b);
    shreg = {shreg[ByteW-2:0], b};
    if (nbits != CountMax) nbits++;
  endfunction

  // advances the predicted decoder by one request, returns 1 when a frame is due
  function automatic bit decode_event(input logic kind, input logic level,
                                      output byte_frame_t fr);
    fr = '0;
    if (kind == KindEdge) begin
      case (ph)
        PH_IDLE: begin
          if (!level) begin
            shreg = '0;
            ph = PH_END_FIRST;
          end
        end
        PH_END_FIRST: begin
          ph = PH_IDLE;
          if (level && fits(since_edge, cfg.start_nominal, cfg.start_tolerance)) begin
            ph = PH_START_END;
            armed = 1'b1;
            frame_count = '0;
            nbits = '0;
          end
        end
        PH_START_START: begin
          if (level) ph = PH_HALTED;
          else ph = PH_END_START;
        end
        PH_END_START: begin
          if (level && fits(since_edge, cfg.start_nominal, cfg.start_tolerance)) begin
            ph = PH_START_END;
          end else begin
            ph = PH_HALTED;
          end
        end
        PH_START_END: begin
          if (level) begin
            ph = PH_HALTED;
          end else begin
            // zero window wins where the two overlap
            if (fits(since_edge, cfg.zero_nominal, cfg.bit_tolerance)) take_bit(1'b0);
            else if (fits(since_edge, cfg.one_nominal, cfg.bit_tolerance)) take_bit(1'b1);
            ph = PH_END_END;
          end
        end
        PH_END_END: begin
          if (level && fits(since_edge, cfg.end_nominal, cfg.end_tolerance)) begin
            ph = PH_START_START;
          end else begin
            ph = PH_HALTED;
          end
        end
        default: ;
      endcase
      since_edge = '0;
      return 1'b0;
    end
    if (since_edge != TickMax) since_edge++;
    if (!armed) return 1'b0;
    if (frame_count != FrameMax) frame_count++;
    if (frame_count < cfg.frame_timeout) return 1'b0;
    armed = 1'b0;
    ph = PH_IDLE;
    fr.data_byte = shreg;
    fr.bits_received = nbits;
    fr.too_many_bits = nbits > ByteBits;
    return 1'b1;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send(logic k, logic l);
    int gap;
    bit hit;
    byte_frame_t fr;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        evt_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    evt_bus.valid <= 1'b1;
    evt_bus.kind <= k;
    evt_bus.level <= l;
    do @(posedge clk); while (!evt_bus.ready);
    events_sent++;
    hit = decode_event(k, l, fr);
    if (given_on) begin
      if (!hit) begin
        $error("directed row expects a frame the predictor does not produce");
        mismatches++;
      end
      fr = given;
      hit = 1'b1;
    end
    if (hit) frames_due.push_back(fr);
    @(negedge clk);
  endtask

  task automatic ticks(int n);
    repeat (n) send(KindTick, 1'($urandom_range(0, 1)));
  endtask

  task automatic wait_quiet();
    evt_bus.valid <= 1'b0;
    burst_left = 0;
    while (frames_due.size() != 0) @(negedge clk);
    repeat (Settle) @(negedge clk);
  endtask

  task automatic set_reg(irpw_reg_t r, logic [DataW-1:0] v);
    logic [DataW-1:0] back;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(4 * r);
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (r)
      REG_START_NOMINAL:   cfg.start_nominal = v[TickW-1:0];
      REG_START_TOLERANCE: cfg.start_tolerance = v[TickW-1:0];
      REG_END_NOMINAL:     cfg.end_nominal = v[TickW-1:0];
      REG_END_TOLERANCE:   cfg.end_tolerance = v[TickW-1:0];
      REG_ZERO_NOMINAL:    cfg.zero_nominal = v[TickW-1:0];
      REG_ONE_NOMINAL:     cfg.one_nominal = v[TickW-1:0];
      REG_BIT_TOLERANCE:   cfg.bit_tolerance = v[TickW-1:0];
      default:             cfg.frame_timeout = v[FrameW-1:0];
    endcase
    // read it straight back
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    back = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (back !== v) begin
      $error("register %s: expected %0d, got %0d", r.name(), v, back);
      mismatches++;
    end
  endtask

  task automatic load_settings(irpw_cfg_t c);
    set_reg(REG_START_NOMINAL, DataW'(c.start_nominal));
    set_reg(REG_START_TOLERANCE, DataW'(c.start_tolerance));
    set_reg(REG_END_NOMINAL, DataW'(c.end_nominal));
    set_reg(REG_END_TOLERANCE, DataW'(c.end_tolerance));
    set_reg(REG_ZERO_NOMINAL, DataW'(c.zero_nominal));
    set_reg(REG_ONE_NOMINAL, DataW'(c.one_nominal));
    set_reg(REG_BIT_TOLERANCE, DataW'(c.bit_tolerance));
    set_reg(REG_FRAME_TIMEOUT, DataW'(c.frame_timeout));
    settings_used++;
  endtask

  function automatic bit good_step(bit broken);
    return !broken || $urandom_range(0, 3) != 0;
  endfunction

  // a pulse length inside the window, or just outside it
  function automatic int len_for(logic [TickW-1:0] nom, logic [TickW-1:0] tol, bit good);
    int lo;
    int hi;
    lo = int'(nom) - int'(tol);
    if (lo < 0) lo = 0;
    hi = int'(nom) + int'(tol);
    if (hi > lo + 30) hi = lo + 30;
    if (!good) begin
      if (lo > 0 && $urandom_range(0, 1) == 1) return lo - 1;
      if (int'(nom) + int'(tol) < 300) return int'(nom) + int'(tol) + 1;
    end
    case ($urandom_range(0, 3))
      0: return lo;
      1: return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  task automatic send_frame(int nb, bit broken);
    bit b;
    send(KindEdge, 1'b0);
    ticks(len_for(cfg.start_nominal, cfg.start_tolerance, good_step(broken)));
    send(KindEdge, 1'b1);
    for (int i = 0; i < nb; i++) begin
      b = $urandom_range(0, 1);
      ticks(len_for(b ? cfg.one_nominal : cfg.zero_nominal, cfg.bit_tolerance,
                    good_step(broken)));
      send(KindEdge, 1'b0);
      ticks(len_for(cfg.end_nominal, cfg.end_tolerance, good_step(broken)));
      send(KindEdge, 1'b1);
      ticks($urandom_range(0, 2));
      send(KindEdge, 1'b0);
      ticks(len_for(cfg.start_nominal, cfg.start_tolerance, good_step(broken)));
      send(KindEdge, 1'b1);
    end
    // run the frame timer out
    while (armed) send(KindTick, 1'($urandom_range(0, 1)));
  endtask

  task automatic run_phase(irpw_cfg_t c, int budget, int max_bits, bit noise_only,
                           bit long_first);
    int first;
    wait_quiet();
    load_settings(c);
    first = events_sent;
    if (long_first) send_frame(68, 1'b0);
    while (events_sent - first < budget) begin
      if (noise_only || $urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 12)) begin
          send(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end else begin
        send_frame($urandom_range(0, max_bits), $urandom_range(0, 4) == 0);
      end
    end
    while (armed) send(KindTick, 1'b0);
  endtask

  function automatic irpw_cfg_t rand_settings();
    irpw_cfg_t c;
    c.start_nominal = TickW'($urandom_range(0, 6));
    c.start_tolerance = TickW'($urandom_range(0, 2));
    c.end_nominal = TickW'($urandom_range(0, 4));
    c.end_tolerance = TickW'($urandom_range(0, 2));
    c.zero_nominal = TickW'($urandom_range(0, 10));
    c.one_nominal = c.zero_nominal + TickW'($urandom_range(0, 10));
    c.bit_tolerance = TickW'($urandom_range(0, 3));
    if ($urandom_range(0, 3) == 0) c.frame_timeout = FrameW'($urandom_range(1, 20));
    else c.frame_timeout = FrameW'($urandom_range(60, 400));
    return c;
  endfunction

  // receiver: changing stall pattern, plus one long hold-off on request
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    logic rdy;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req) begin
        stall_req = 1'b0;
        hold_left = HoldOff;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(5, 80);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        case (mode)
          0, 1: rdy = 1'b1;
          2: rdy = 1'($urandom_range(0, 1));
          default: rdy = ($urandom_range(0, 3) == 0);
        endcase
      end
      res_bus.ready <= rdy;
    end
  end

  always @(posedge clk) begin
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (frames_due.size() == 0) begin
        $error("unexpected frame: data_byte %0h bits_received %0d", res_bus.data_byte,
               res_bus.bits_received);
        mismatches++;
      end else begin
        want = frames_due.pop_front();
        frames_checked++;
        if (res_bus.data_byte !== want.data_byte) begin
          $error("data_byte: expected %0h, got %0h", want.data_byte, res_bus.data_byte);
          mismatches++;
        end
        if (res_bus.bits_received !== want.bits_received) begin
          $error("bits_received: expected %0d, got %0d", want.bits_received,
                 res_bus.bits_received);
          mismatches++;
        end
        if (res_bus.too_many_bits !== want.too_many_bits) begin
          $error("too_many_bits: expected %0b, got %0b", want.too_many_bits,
                 res_bus.too_many_bits);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL ir_pulse_width_byte_decoder");
    $finish;
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    evt_bus.valid = 1'b0;
    evt_bus.kind = KindTick;
    evt_bus.level = 1'b0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    load_settings('{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd1, 12'd0, 16'd3});
    foreach (probes[i]) begin
      given_on = probes[i].typed;
      given = '{probes[i].data_byte, probes[i].bits_received, probes[i].too_many_bits};
      send(probes[i].kind, probes[i].level);
      given_on = 1'b0;
    end

    run_phase('{StartNominalRst, StartToleranceRst, EndNominalRst, EndToleranceRst,
                ZeroNominalRst, OneNominalRst, BitToleranceRst, FrameTimeoutRst},
              500, 9, 1'b0, 1'b0);
    // every window collapsed to zero, shortest timer
    run_phase('{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 16'd1},
              150, 6, 1'b0, 1'b0);
    // tight windows and a long timer so the bit count saturates
    run_phase('{12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd1, 12'd0, 16'd250},
              400, 70, 1'b0, 1'b1);
    // widest windows: every length matches, zero always wins
    run_phase('{12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095,
                16'd40}, 200, 12, 1'b0, 1'b0);
    // largest values, start window never met
    run_phase('{12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd0, 16'd65535},
              120, 0, 1'b1, 1'b0);
    // short frames while the receiver holds off, input backs up
    stall_req = 1'b1;
    run_phase('{12'd1, 12'd1, 12'd1, 12'd1, 12'd2, 12'd5, 12'd1, 16'd12},
              250, 3, 1'b0, 1'b0);
    while ((events_sent < 1950 || frames_checked < 48) && settings_used < 60) begin
      run_phase(rand_settings(), 200, 10, 1'b0, 1'b0);
    end

    wait_quiet();
    repeat (10) @(negedge clk);
    $display("sent %0d events under %0d register settings, compared %0d frames",
             events_sent, settings_used, frames_checked);
    $display("window edges, halts, expiry, bit count saturation and a long stall included");
    if (mismatches == 0) begin
      $display("PASS ir_pulse_width_byte_decoder");
    end else begin
      $display("FAIL ir_pulse_width_byte_decoder");
    end
    $finish;
  end

endmodule

[files.f]
rtl/irpw_pkg.sv
rtl/irpw_if.sv
rtl/irpw_cfg_regs.sv
rtl/irpw_core.sv
rtl/ir_pulse_width_byte_decoder.sv
tb/sv/tb_ir_pulse_width_byte_decoder.sv
